// ===== src/mclb_pkg.sv =====
package mclb_pkg;

    localparam int CMD_W = 3;

    localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_STATIC  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALL         = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BLINK_ON    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BLINK_OFF   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_OUTPUTS_OFF = 3'd5;
    localparam logic [CMD_W-1:0] CMD_OUTPUTS_ON  = 3'd6;

    // control part of a registered command item
    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] cmd;
        logic             level;
    } item_ctl_t;

endpackage

// ===== src/mclb_in_stage.sv =====
module mclb_in_stage #(
    parameter int NUM_CHANNELS = 5,
    parameter int DIVIDER_BITS = 5
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cmd_valid,
    input  logic [mclb_pkg::CMD_W-1:0]             cmd,
    input  logic [NUM_CHANNELS-1:0]                channel_mask,
    input  logic                                   level,
    input  logic [NUM_CHANNELS*DIVIDER_BITS-1:0]   packed_rates,
    input  logic                                   out_free,
    output logic                                   cmd_stall,
    output mclb_pkg::item_ctl_t                    item_ctl,
    output logic [NUM_CHANNELS-1:0]                item_mask,
    output logic [NUM_CHANNELS*DIVIDER_BITS-1:0]   item_rates
);

    logic                                 valid_reg;
    logic                                 valid_next;
    logic [mclb_pkg::CMD_W-1:0]           cmd_reg;
    logic                                 level_reg;
    logic [NUM_CHANNELS-1:0]              mask_reg;
    logic [NUM_CHANNELS*DIVIDER_BITS-1:0] rates_reg;
    logic                                 load;

    // held item only blocks when the result side cannot take it
    assign cmd_stall  = valid_reg && !out_free;
    assign load       = !cmd_stall;
    assign valid_next = load ? cmd_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && cmd_valid)
        begin
            cmd_reg   <= cmd;
            level_reg <= level;
            mask_reg  <= channel_mask;
            rates_reg <= packed_rates;
        end
    end

    assign item_ctl.valid = valid_reg;
    assign item_ctl.cmd   = cmd_reg;
    assign item_ctl.level = level_reg;
    assign item_mask      = mask_reg;
    assign item_rates     = rates_reg;

endmodule

// ===== src/mclb_core.sv =====
module mclb_core #(
    parameter int NUM_CHANNELS = 5,
    parameter int DIVIDER_BITS = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mclb_pkg::item_ctl_t                  item_ctl,
    input  logic [NUM_CHANNELS-1:0]              item_mask,
    input  logic [NUM_CHANNELS*DIVIDER_BITS-1:0] item_rates,
    input  logic                                 out_free,
    output logic                                 fire,
    output logic                                 emit,
    output logic [NUM_CHANNELS-1:0]              pattern
);

    logic [NUM_CHANNELS-1:0] static_reg, static_next;
    logic [NUM_CHANNELS-1:0] blink_reg, blink_next;
    logic [NUM_CHANNELS-1:0] phase_reg, phase_next;
    logic                    active_reg, active_next;
    logic [DIVIDER_BITS-1:0] div_reg  [NUM_CHANNELS];
    logic [DIVIDER_BITS-1:0] div_next [NUM_CHANNELS];
    logic [DIVIDER_BITS-1:0] cnt_reg  [NUM_CHANNELS];
    logic [DIVIDER_BITS-1:0] cnt_next [NUM_CHANNELS];

    assign fire = item_ctl.valid && out_free;

    always_comb
    begin
        logic                    do_update;
        logic                    flip;
        logic [DIVIDER_BITS:0]   inc;

        do_update   = 1'b0;
        flip        = 1'b0;
        inc         = '0;
        emit        = 1'b0;
        pattern     = '0;
        static_next = static_reg;
        blink_next  = blink_reg;
        phase_next  = phase_reg;
        active_next = active_reg;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            div_next[i] = div_reg[i];
            cnt_next[i] = cnt_reg[i];
        end

        case (item_ctl.cmd)
            mclb_pkg::CMD_TICK:
            begin
                if (active_reg)
                begin
                    do_update = 1'b1;
                    flip      = 1'b1;
                end
                else
                begin
                    phase_next = '1;
                end
            end
            mclb_pkg::CMD_SET_STATIC:
            begin
                static_next = item_ctl.level ? (static_reg | item_mask)
                                             : (static_reg & ~item_mask);
                emit    = 1'b1;
                pattern = static_next;
            end
            mclb_pkg::CMD_ALL:
            begin
                static_next = item_ctl.level ? '1 : '0;
                emit    = 1'b1;
                pattern = static_next;
            end
            mclb_pkg::CMD_BLINK_ON:
            begin
                if (item_mask != '0)
                begin
                    blink_next = blink_reg | item_mask;
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        if (item_mask[i])
                        begin
                            div_next[i] = item_rates[i*DIVIDER_BITS +: DIVIDER_BITS];
                            cnt_next[i] = '0;
                        end
                    end
                    active_next = 1'b1;
                    do_update   = 1'b1;
                end
            end
            mclb_pkg::CMD_BLINK_OFF:
            begin
                if (item_mask != '0)
                begin
                    blink_next = blink_reg & ~item_mask;
                    if (blink_next == '0)
                    begin
                        active_next = 1'b0;
                        emit        = 1'b1;
                        pattern     = static_reg;
                    end
                    else
                    begin
                        do_update = active_reg;
                    end
                end
            end
            mclb_pkg::CMD_OUTPUTS_OFF:
            begin
                emit    = 1'b1;
                pattern = '0;
            end
            mclb_pkg::CMD_OUTPUTS_ON:
            begin
                emit    = 1'b1;
                pattern = static_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // blink update: show the current phase, then advance the counters
        if (do_update)
        begin
            emit    = 1'b1;
            pattern = (static_reg & ~blink_next) | (phase_reg & blink_next);
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (blink_next[i])
                begin
                    inc = {1'b0, cnt_next[i]} + {{DIVIDER_BITS{1'b0}}, 1'b1};
                    if (inc < {1'b0, div_next[i]})
                    begin
                        cnt_next[i] = inc[DIVIDER_BITS-1:0];
                    end
                    else if (flip)
                    begin
                        cnt_next[i]   = '0;
                        phase_next[i] = ~phase_reg[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            static_reg <= '0;
            blink_reg  <= '0;
            phase_reg  <= '1;
            active_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                div_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            static_reg <= static_next;
            blink_reg  <= blink_next;
            phase_reg  <= phase_next;
            active_reg <= active_next;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                div_reg[i] <= div_next[i];
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule

// ===== src/mclb_out_stage.sv =====
module mclb_out_stage #(
    parameter int NUM_CHANNELS = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  logic                    emit,
    input  logic [NUM_CHANNELS-1:0] pattern,
    input  logic                    led_stall,
    output logic                    out_free,
    output logic                    led_valid,
    output logic [NUM_CHANNELS-1:0] led_pattern
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [NUM_CHANNELS-1:0] pattern_reg;

    assign out_free   = !valid_reg || !led_stall;
    assign valid_next = out_free ? (fire && emit) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && fire && emit)
        begin
            pattern_reg <= pattern;
        end
    end

    assign led_valid   = valid_reg;
    assign led_pattern = pattern_reg;

endmodule

// ===== src/multi_channel_led_blinker_unit.sv =====
// Item path: an accepted command item sits in the input register and is
//   executed once the result register can take it, which loads the result.
// Throughput: one command item per cycle. The command side stalls only while
//   an item waits in the input register and a held pattern meets led_stall.
// Reset: rst_n async, active low; clears the pattern, blink state, dividers
//   and counters, sets every blink phase lit and empties both registers.
module multi_channel_led_blinker_unit #(
    parameter int NUM_CHANNELS = 5,
    parameter int DIVIDER_BITS = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // command channel
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  logic [mclb_pkg::CMD_W-1:0]           cmd,
    input  logic [NUM_CHANNELS-1:0]              channel_mask,
    input  logic                                 level,
    input  logic [NUM_CHANNELS*DIVIDER_BITS-1:0] packed_rates,
    // LED pattern channel
    output logic                                 led_valid,
    input  logic                                 led_stall,
    output logic [NUM_CHANNELS-1:0]              led_pattern
);

    // Item flow:
    //   in_stage  - registers the accepted command item.
    //   core      - holds the LED state (static pattern, blink set, phase,
    //               per-channel divider and counter) and computes the next
    //               state and the optional pattern in one pass.
    //   out_stage - result register; parts the stall of the LED side from
    //               the command side so a new item enters while a pattern
    //               waits, as long as the held item can move on.
    // The held item is executed (state written) only in a cycle where the
    // result register can take it, so a stalled result never loses or
    // repeats a pattern. Items that give no pattern pass through the same way.

    mclb_pkg::item_ctl_t                  item_ctl;
    logic [NUM_CHANNELS-1:0]              item_mask;
    logic [NUM_CHANNELS*DIVIDER_BITS-1:0] item_rates;
    logic                                 out_free;
    logic                                 fire;
    logic                                 emit;
    logic [NUM_CHANNELS-1:0]              pattern;

    mclb_in_stage #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .DIVIDER_BITS (DIVIDER_BITS)
    ) u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .channel_mask (channel_mask),
        .level        (level),
        .packed_rates (packed_rates),
        .out_free     (out_free),
        .cmd_stall    (cmd_stall),
        .item_ctl     (item_ctl),
        .item_mask    (item_mask),
        .item_rates   (item_rates)
    );

    // During the dark phase a blinking channel is forced off, whatever the
    // static pattern says for it.
    mclb_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .DIVIDER_BITS (DIVIDER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ctl   (item_ctl),
        .item_mask  (item_mask),
        .item_rates (item_rates),
        .out_free   (out_free),
        .fire       (fire),
        .emit       (emit),
        .pattern    (pattern)
    );

    mclb_out_stage #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .emit        (emit),
        .pattern     (pattern),
        .led_stall   (led_stall),
        .out_free    (out_free),
        .led_valid   (led_valid),
        .led_pattern (led_pattern)
    );

endmodule

// ===== src/mclb_checker.sv =====
module mclb_checker #(
    parameter int NUM_CHANNELS = 5
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cmd_valid,
    input logic                                 cmd_stall,
    input logic [mclb_pkg::CMD_W-1:0]           cmd,
    input logic                                 level,
    input logic                                 led_valid,
    input logic                                 led_stall,
    input logic [NUM_CHANNELS-1:0]              led_pattern
);

    logic cmd_take;
    logic led_free;

    assign cmd_take = cmd_valid && !cmd_stall;
    assign led_free = !led_valid || !led_stall;

    // stalled result holds
    a_led_hold: assert property (@(posedge clk) disable iff (!rst_n)
        led_valid && led_stall |=> led_valid && $stable(led_pattern))
        else $error("led item changed while stalled");

    // with no result waiting, the command side is never stalled
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !led_valid |-> !cmd_stall)
        else $error("command stalled with empty result register");

    a_outputs_off: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && cmd == mclb_pkg::CMD_OUTPUTS_OFF ##1 led_free
        |=> led_valid && led_pattern == '0)
        else $error("outputs off did not give a dark pattern");

    a_all_on: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && cmd == mclb_pkg::CMD_ALL && level ##1 led_free
        |=> led_valid && led_pattern == '1)
        else $error("all on did not light every channel");

    // undefined command leaves no result
    a_undefined: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && cmd != mclb_pkg::CMD_TICK && cmd != mclb_pkg::CMD_SET_STATIC
        && cmd != mclb_pkg::CMD_ALL && cmd != mclb_pkg::CMD_BLINK_ON
        && cmd != mclb_pkg::CMD_BLINK_OFF && cmd != mclb_pkg::CMD_OUTPUTS_OFF
        && cmd != mclb_pkg::CMD_OUTPUTS_ON ##1 led_free |=> !led_valid)
        else $error("undefined command produced an item");

endmodule

bind multi_channel_led_blinker_unit mclb_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_mclb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .level        (level),
    .led_valid    (led_valid),
    .led_stall    (led_stall),
    .led_pattern  (led_pattern)
);
